// File: rtl/mfpe_pkg.sv
// Shared types, codes and word functions of the masked firmware patch engine.
// Used by the top level; the generic RAM does not depend on it.
package mfpe_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_PATCH = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_PATCH = 1'b1;

    localparam logic [1:0] OUT_NONE      = 2'd0;
    localparam logic [1:0] OUT_INSTALLED = 2'd1;
    localparam logic [1:0] OUT_REMOVED   = 2'd2;

    localparam logic [1:0] PS_INSTALLABLE = 2'd1;
    localparam logic [1:0] PS_INSTALLED   = 2'd2;

    localparam logic [31:0] MEM_BASE = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] byte_address;
        logic [31:0] data_word;
        logic [31:0] original_word;
        logic [31:0] patched_word;
        logic [31:0] search_mask;
        logic [31:0] write_mask;
        logic        last_word;
        logic        install;
        logic [1:0]  patch_state;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] read_data;
        logic [1:0]  outcome;
        logic [1:0]  new_patch_state;
    } rsp_t;

    // Words of one buffered patch entry, without its word index.
    typedef struct packed {
        logic [31:0] original_word;
        logic [31:0] patched_word;
        logic [31:0] search_mask;
        logic [31:0] write_mask;
    } patch_words_t;

    function automatic logic word_passes(input logic inst, input logic [31:0] mem,
                                         input patch_words_t w);
        logic [31:0] want;
        logic        ok;
        if (inst) begin
            ok = (mem & w.search_mask) == (w.original_word & w.search_mask);
        end else begin
            want = (w.original_word & w.search_mask & ~w.write_mask)
                 | (w.patched_word & w.write_mask);
            ok = ((w.write_mask & ~w.search_mask) == 32'd0)
              && ((mem & (w.search_mask | w.write_mask)) == want);
        end
        return ok;
    endfunction

    function automatic logic [31:0] word_applied(input logic inst, input logic [31:0] mem,
                                                 input patch_words_t w);
        logic [31:0] src;
        src = inst ? w.patched_word : w.original_word;
        return (src & w.write_mask) | (mem & ~w.write_mask);
    endfunction

endpackage

// File: rtl/mfpe_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// A read at the address being written returns the old data. No dependencies.
module mfpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/masked_firmware_patch_engine.sv
// Top level of the masked firmware patch engine: control, address decode and
// the firmware and patch buffer RAMs. Depends on mfpe_pkg and mfpe_ram.
//
// Usage: an item is offered on request and taken when start is high while
// busy is low. Results appear on result for exactly one cycle with done high;
// the receiver cannot hold them off and none is ever dropped.
//   Write item: no result, and busy stays low, so the next item may follow at once.
//   Read item: busy in the read state, which registers the reply from the
//   registered read of the firmware RAM; the next item may be taken as it is shown.
//   Patch word that is not last: written into the patch buffer; the next item may follow at once.
//   Last patch word of a valid run: the buffer is walked through a
//   three-stage pipeline (buffer read, firmware read, compare or write), once
//   to check and, if every word passes, once to apply. An invalid or
//   inapplicable run reports its outcome in the cycle after the item.
// Back-to-back writes to the same firmware word during apply are forwarded.
// Reset clears the control state and the buffer fill count; firmware memory
// and buffer contents are undefined until written. No clearing pass is run.
module masked_firmware_patch_engine #(
    parameter int FIRMWARE_WORDS = 65536,
    parameter int PATCH_WORDS    = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mfpe_pkg::req_t  request,
    output logic            done,
    output mfpe_pkg::rsp_t  result
);
    import mfpe_pkg::*;

    localparam int FW_AW = $clog2(FIRMWARE_WORDS);
    localparam int BUF_AW = (PATCH_WORDS > 1) ? $clog2(PATCH_WORDS) : 1;
    localparam int CW = $clog2(PATCH_WORDS + 1);
    localparam int BUF_W = FW_AW + $bits(patch_words_t);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_APPLY = 2'd3;

    logic [1:0]       state_reg;
    logic [CW-1:0]    count_reg;
    logic             invalid_reg;
    logic [CW-1:0]    issue_reg;
    logic [CW-1:0]    run_n_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             fail_reg;
    logic             inst_reg;
    logic [1:0]       pstate_reg;
    logic             read_ok_reg;
    logic             fwd_valid_reg;
    logic [FW_AW-1:0] fwd_idx_reg;
    logic [31:0]      fwd_data_reg;
    logic [BUF_W-1:0] ent_reg;
    logic             done_reg;
    rsp_t             result_reg;

    logic             accept;
    logic [31:0]      offset;
    logic             addr_ok;
    logic [FW_AW-1:0] addr_idx;
    logic             patch_take;
    logic             patch_bad;
    logic [CW-1:0]    count_after;
    logic             mode_ok;
    logic             run_phase;
    logic             issuing;
    logic             phase_end;
    logic             last_accept;
    logic             fin_now;
    logic [FW_AW-1:0] ent_idx;
    patch_words_t     ent_words;
    logic [31:0]      mem_cur;
    logic             fw_we;
    logic [FW_AW-1:0] fw_waddr;
    logic [31:0]      fw_wdata;
    logic [FW_AW-1:0] fw_raddr;
    logic [31:0]      fw_rdata;
    logic [BUF_W-1:0] buf_wdata;
    logic [BUF_W-1:0] buf_rdata;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    assign offset = request.byte_address - MEM_BASE;
    assign addr_ok = (request.byte_address >= MEM_BASE)
                  && (offset[31:2] < 30'(FIRMWARE_WORDS));
    assign addr_idx = offset[FW_AW+1:2];

    assign patch_take = accept && (request.req_type == REQ_PATCH) && addr_ok
                     && (count_reg < CW'(PATCH_WORDS));
    assign patch_bad = accept && (request.req_type == REQ_PATCH) && !patch_take;
    assign count_after = patch_take ? count_reg + CW'(1) : count_reg;
    assign last_accept = accept && (request.req_type == REQ_PATCH) && request.last_word;
    assign mode_ok = (request.patch_state[0] && request.install)
                  || ((request.patch_state == PS_INSTALLED) && !request.install);
    // A run that is invalid or matches neither install nor removal ends at once.
    assign fin_now = last_accept && (invalid_reg || patch_bad || !mode_ok);

    assign run_phase = (state_reg == ST_CHECK) || (state_reg == ST_APPLY);
    assign issuing = run_phase && (issue_reg < run_n_reg);
    assign phase_end = run_phase && !issuing && !v1_reg && !v2_reg;

    assign ent_idx = ent_reg[BUF_W-1 -: FW_AW];
    assign ent_words = patch_words_t'(ent_reg[$bits(patch_words_t)-1:0]);
    // The write of the previous entry lands on the same edge as this entry's
    // read, so the RAM returns the old word; take the written one instead.
    assign mem_cur = (fwd_valid_reg && (fwd_idx_reg == ent_idx)) ? fwd_data_reg : fw_rdata;

    assign fw_we = (accept && (request.req_type == REQ_WRITE) && addr_ok)
                || ((state_reg == ST_APPLY) && v2_reg);
    assign fw_waddr = (state_reg == ST_APPLY) ? ent_idx : addr_idx;
    assign fw_wdata = (state_reg == ST_APPLY) ? word_applied(inst_reg, mem_cur, ent_words)
                                              : request.data_word;
    assign fw_raddr = (state_reg == ST_IDLE) ? addr_idx : buf_rdata[BUF_W-1 -: FW_AW];

    assign buf_wdata = {addr_idx, request.original_word, request.patched_word,
                        request.search_mask, request.write_mask};

    mfpe_ram #(
        .WIDTH (32),
        .DEPTH (FIRMWARE_WORDS),
        .AW    (FW_AW)
    ) u_fw_ram (
        .clk   (clk),
        .we    (fw_we),
        .waddr (fw_waddr),
        .wdata (fw_wdata),
        .raddr (fw_raddr),
        .rdata (fw_rdata)
    );

    mfpe_ram #(
        .WIDTH (BUF_W),
        .DEPTH (PATCH_WORDS),
        .AW    (BUF_AW)
    ) u_buf_ram (
        .clk   (clk),
        .we    (patch_take),
        .waddr (count_reg[BUF_AW-1:0]),
        .wdata (buf_wdata),
        .raddr (issue_reg[BUF_AW-1:0]),
        .rdata (buf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            invalid_reg   <= 1'b0;
            issue_reg     <= '0;
            run_n_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            fail_reg      <= 1'b0;
            inst_reg      <= 1'b0;
            read_ok_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            v1_reg <= issuing;
            v2_reg <= v1_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (request.req_type == REQ_READ))
                    begin
                        read_ok_reg <= addr_ok;
                        state_reg <= ST_READ;
                    end
                    if (accept && (request.req_type == REQ_PATCH))
                    begin
                        if (request.last_word)
                        begin
                            count_reg <= '0;
                            invalid_reg <= 1'b0;
                            if (fin_now)
                            begin
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_CHECK;
                                issue_reg <= '0;
                                fail_reg <= 1'b0;
                                run_n_reg <= count_after;
                                inst_reg <= request.install;
                            end
                        end
                        else
                        begin
                            count_reg <= count_after;
                            invalid_reg <= invalid_reg | patch_bad;
                        end
                    end
                end
                ST_READ:
                begin
                    done_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_CHECK:
                begin
                    if (issuing)
                    begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                    if (v2_reg && !word_passes(inst_reg, fw_rdata, ent_words))
                    begin
                        fail_reg <= 1'b1;
                    end
                    if (phase_end)
                    begin
                        if (fail_reg)
                        begin
                            done_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_APPLY;
                            issue_reg <= '0;
                            fwd_valid_reg <= 1'b0;
                        end
                    end
                end
                ST_APPLY:
                begin
                    if (issuing)
                    begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                    if (v2_reg)
                    begin
                        fwd_valid_reg <= 1'b1;
                    end
                    if (phase_end)
                    begin
                        done_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            ent_reg <= buf_rdata;
        end
        if ((state_reg == ST_APPLY) && v2_reg)
        begin
            fwd_idx_reg <= ent_idx;
            fwd_data_reg <= fw_wdata;
        end
        if (last_accept)
        begin
            pstate_reg <= request.patch_state;
        end

        if (state_reg == ST_READ)
        begin
            result_reg.result_kind <= KIND_READ;
            result_reg.read_data <= read_ok_reg ? fw_rdata : 32'd0;
            result_reg.outcome <= OUT_NONE;
            result_reg.new_patch_state <= 2'd0;
        end
        else if (fin_now)
        begin
            result_reg.result_kind <= KIND_PATCH;
            result_reg.read_data <= 32'd0;
            result_reg.outcome <= OUT_NONE;
            result_reg.new_patch_state <= request.patch_state;
        end
        else if ((state_reg == ST_CHECK) && phase_end && fail_reg)
        begin
            result_reg.result_kind <= KIND_PATCH;
            result_reg.read_data <= 32'd0;
            result_reg.outcome <= OUT_NONE;
            result_reg.new_patch_state <= pstate_reg;
        end
        else if ((state_reg == ST_APPLY) && phase_end)
        begin
            result_reg.result_kind <= KIND_PATCH;
            result_reg.read_data <= 32'd0;
            result_reg.outcome <= inst_reg ? OUT_INSTALLED : OUT_REMOVED;
            result_reg.new_patch_state <= inst_reg ? PS_INSTALLED : PS_INSTALLABLE;
        end
    end

endmodule

// File: test/mfpe_checker.sv
// Checker for the masked firmware patch engine: keeps its own copy of the
// firmware memory and patch buffer, predicts every result and compares it.
// Depends on mfpe_pkg.
`timescale 1ns / 100ps

module mfpe_checker #(
    parameter int FIRMWARE_WORDS = 65536,
    parameter int PATCH_WORDS    = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  mfpe_pkg::req_t   request,
    input  logic             done,
    input  mfpe_pkg::rsp_t   result,
    output int               mismatches,
    output int               outstanding
);
    import mfpe_pkg::*;

    typedef struct packed {
        logic [31:0]  slot;
        patch_words_t w;
    } staged_word_t;

    logic [31:0]  fw_mem [FIRMWARE_WORDS];
    staged_word_t staged[$];
    logic         run_broken = 1'b0;
    rsp_t         pending_results[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    function automatic logic decode_slot(input logic [31:0] addr, output logic [31:0] slot);
        logic [31:0] offset;
        offset = addr - MEM_BASE;
        slot = offset >> 2;
        return (addr >= MEM_BASE) && (slot < FIRMWARE_WORDS);
    endfunction

    // Checks all buffered words against memory first, then writes them in
    // buffer order, so a later word sees the writes of earlier ones.
    function automatic logic [1:0] settle_patch(input logic inst, input logic [1:0] state);
        logic        pass;
        logic [31:0] cur;
        logic [31:0] want;
        logic [31:0] sm;
        logic [31:0] wm;
        pass = 1'b1;
        if (run_broken)
            return OUT_NONE;
        if (state[0] && inst)
        begin
            foreach (staged[i])
            begin
                sm = staged[i].w.search_mask;
                if ((fw_mem[staged[i].slot] & sm) != (staged[i].w.original_word & sm))
                    pass = 1'b0;
            end
            if (!pass)
                return OUT_NONE;
            foreach (staged[i])
            begin
                wm = staged[i].w.write_mask;
                cur = fw_mem[staged[i].slot];
                fw_mem[staged[i].slot] = (staged[i].w.patched_word & wm) | (cur & ~wm);
            end
            return OUT_INSTALLED;
        end
        if (state == PS_INSTALLED && !inst)
        begin
            foreach (staged[i])
            begin
                sm = staged[i].w.search_mask;
                wm = staged[i].w.write_mask;
                want = (staged[i].w.original_word & sm & ~wm) | (staged[i].w.patched_word & wm);
                if ((wm & ~sm) != 32'd0 || (fw_mem[staged[i].slot] & (sm | wm)) != want)
                    pass = 1'b0;
            end
            if (!pass)
                return OUT_NONE;
            foreach (staged[i])
            begin
                wm = staged[i].w.write_mask;
                cur = fw_mem[staged[i].slot];
                fw_mem[staged[i].slot] = (cur & ~wm) | (staged[i].w.original_word & wm);
            end
            return OUT_REMOVED;
        end
        return OUT_NONE;
    endfunction

    task automatic apply_request(input req_t r);
        logic [31:0]  slot;
        logic         hit;
        rsp_t         e;
        staged_word_t sw;
        hit = decode_slot(r.byte_address, slot);
        e = '0;
        case (r.req_type)
            REQ_WRITE:
                if (hit)
                    fw_mem[slot] = r.data_word;
            REQ_READ:
            begin
                e.result_kind = KIND_READ;
                e.read_data = hit ? fw_mem[slot] : 32'd0;
                pending_results.push_back(e);
            end
            REQ_PATCH:
            begin
                if (!hit || staged.size() >= PATCH_WORDS)
                    run_broken = 1'b1;
                else
                begin
                    sw.slot = slot;
                    sw.w = '{r.original_word, r.patched_word, r.search_mask, r.write_mask};
                    staged.push_back(sw);
                end
                if (r.last_word)
                begin
                    e.result_kind = KIND_PATCH;
                    e.outcome = settle_patch(r.install, r.patch_state);
                    if (e.outcome == OUT_INSTALLED)
                        e.new_patch_state = PS_INSTALLED;
                    else if (e.outcome == OUT_REMOVED)
                        e.new_patch_state = PS_INSTALLABLE;
                    else
                        e.new_patch_state = r.patch_state;
                    pending_results.push_back(e);
                    staged.delete();
                    run_broken = 1'b0;
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t e;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result %h arrived with nothing expected", got));
            return;
        end
        e = pending_results.pop_front();
        if (got.result_kind !== e.result_kind)
            report($sformatf("result_kind %b, expected %b", got.result_kind, e.result_kind));
        if (got.read_data !== e.read_data)
            report($sformatf("read_data %h, expected %h", got.read_data, e.read_data));
        if (got.outcome !== e.outcome)
            report($sformatf("outcome %0d, expected %0d", got.outcome, e.outcome));
        if (got.new_patch_state !== e.new_patch_state)
            report($sformatf("new_patch_state %0d, expected %0d",
                             got.new_patch_state, e.new_patch_state));
    endtask

    // A result leaving at this edge is older than an item taken at it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                check_result(result);
            if (start === 1'b1 && busy === 1'b0)
                apply_request(request);
            outstanding = pending_results.size();
        end
    end

endmodule

// File: test/masked_firmware_patch_engine_tb.sv
// Testbench top for the masked firmware patch engine: directed and random
// items in several idling phases, checked by mfpe_checker.
// Depends on mfpe_pkg, mfpe_checker and the engine itself.
`timescale 1ns / 100ps

module masked_firmware_patch_engine_tb;
    import mfpe_pkg::*;

    localparam int FIRMWARE_WORDS = 65536;
    localparam int PATCH_WORDS    = 256;
    localparam int ITEM_TARGET    = 750;
    localparam int DRAIN_CYCLES   = 2 * PATCH_WORDS + 32;
    localparam int TIMEOUT_NS     = 4_000_000;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [1:0] PS_NONE  = 2'd0;

    typedef enum {RUN_INSTALL, RUN_REMOVE, RUN_NOISE} run_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;
    int   mismatches;
    int   outstanding;
    int   idle_pct;
    int   items_sent;

    logic [15:0] live[$];
    bit          written [FIRMWARE_WORDS];
    req_t        last_install[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    masked_firmware_patch_engine #(
        .FIRMWARE_WORDS(FIRMWARE_WORDS),
        .PATCH_WORDS(PATCH_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    mfpe_checker #(
        .FIRMWARE_WORDS(FIRMWARE_WORDS),
        .PATCH_WORDS(PATCH_WORDS)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    function automatic req_t noise_item();
        req_t r;
        r.req_type      = 2'($urandom);
        r.byte_address  = $urandom;
        r.data_word     = $urandom;
        r.original_word = $urandom;
        r.patched_word  = $urandom;
        r.search_mask   = $urandom;
        r.write_mask    = $urandom;
        r.last_word     = 1'($urandom);
        r.install       = 1'($urandom);
        r.patch_state   = 2'($urandom);
        return r;
    endfunction

    function automatic logic [31:0] slot_address(input logic [15:0] slot);
        return MEM_BASE + {14'd0, slot, 2'($urandom)};
    endfunction

    function automatic logic [31:0] stray_address();
        case ($urandom_range(3))
            0: return $urandom & 32'h7FFF_FFFF;
            1: return 32'h8004_0000 + ($urandom % 32'h7FFC_0000);
            2: return 32'h8004_0000 | 32'($urandom_range(3));
            default: return 32'h7FFF_FFFC | 32'($urandom_range(3));
        endcase
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_live();
        return live[$urandom_range(live.size() - 1)];
    endfunction

    function automatic req_t make_write(input logic [31:0] addr, input logic [31:0] data);
        req_t r;
        r = noise_item();
        r.req_type = REQ_WRITE;
        r.byte_address = addr;
        r.data_word = data;
        return r;
    endfunction

    function automatic req_t make_read(input logic [31:0] addr);
        req_t r;
        r = noise_item();
        r.req_type = REQ_READ;
        r.byte_address = addr;
        return r;
    endfunction

    function automatic req_t make_patch(input logic [31:0] addr, input logic [31:0] orig,
                                        input logic [31:0] patched, input logic [31:0] sm,
                                        input logic [31:0] wm, input logic last,
                                        input logic inst, input logic [1:0] state);
        req_t r;
        r = noise_item();
        r.req_type = REQ_PATCH;
        r.byte_address = addr;
        r.original_word = orig;
        r.patched_word = patched;
        r.search_mask = sm;
        r.write_mask = wm;
        r.last_word = last;
        r.install = inst;
        r.patch_state = state;
        return r;
    endfunction

    // Holds start low for a random number of cycles, then offers the item
    // and keeps it up until the engine takes it.
    task automatic send_item(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (r.req_type != REQ_NONE)
            items_sent++;
    endtask

    task automatic write_word(input logic [15:0] slot, input logic [31:0] data);
        send_item(make_write(slot_address(slot), data));
        if (!written[slot])
        begin
            written[slot] = 1'b1;
            live.push_back(slot);
        end
    endtask

    // Builds a whole patch and sends its words back to back. Install runs take
    // their original words from the current memory so most of them pass; a
    // removal replays the last install run.
    task automatic patch_run(input run_kind_t kind_in, input int n);
        run_kind_t   kind;
        req_t        r;
        req_t        words[$];
        logic [15:0] slot;
        logic [15:0] prev_slot;
        logic [31:0] mem;
        int          last;
        kind = kind_in;
        prev_slot = pick_live();
        if (kind == RUN_REMOVE && last_install.size() == 0)
            kind = RUN_NOISE;
        if (kind == RUN_REMOVE)
        begin
            words = last_install;
            last = words.size() - 1;
            words[last].install = 1'b0;
            words[last].patch_state = ($urandom_range(9) != 0) ? PS_INSTALLED : 2'($urandom);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                r = noise_item();
                r.req_type = REQ_PATCH;
                r.last_word = (i == n - 1);
                slot = (i > 0 && $urandom_range(6) == 0) ? prev_slot : pick_live();
                prev_slot = slot;
                r.byte_address = slot_address(slot);
                r.search_mask = rand_mask();
                if (kind == RUN_NOISE)
                begin
                    r.write_mask = rand_mask();
                    if ($urandom_range(9) == 0)
                        r.byte_address = stray_address();
                end
                else
                begin
                    r.write_mask = ($urandom_range(9) == 0) ? rand_mask()
                                                            : (r.search_mask & rand_mask());
                    mem = chk.fw_mem[slot];
                    r.original_word = (mem & r.search_mask) | ($urandom & ~r.search_mask);
                    if (n <= 32 && $urandom_range(19) == 0)
                        r.original_word ^= 32'd1 << $urandom_range(31);
                    if (n <= 32 && $urandom_range(39) == 0)
                        r.byte_address = stray_address();
                    if (r.last_word)
                    begin
                        r.install = 1'b1;
                        r.patch_state = {1'($urandom), 1'b1};
                    end
                end
                words.push_back(r);
            end
            if (kind == RUN_INSTALL && n <= PATCH_WORDS)
                last_install = words;
        end
        foreach (words[i])
            send_item(words[i]);
    endtask

    task automatic random_item();
        req_t r;
        case ($urandom_range(19))
            0, 1, 2, 3:
                write_word(($urandom_range(2) == 0) ? 16'($urandom) : pick_live(), $urandom);
            4:
                send_item(make_write(stray_address(), $urandom));
            5, 6, 7:
                send_item(make_read(slot_address(pick_live())));
            8:
                send_item(make_read(stray_address()));
            9:
            begin
                r = noise_item();
                r.req_type = REQ_NONE;
                send_item(r);
            end
            10, 11, 12, 13, 14, 15:
                patch_run(RUN_INSTALL, ($urandom_range(9) == 0) ? $urandom_range(24, 7)
                                                                : $urandom_range(6, 1));
            16, 17:
                patch_run(RUN_REMOVE, 0);
            default:
                patch_run(RUN_NOISE, $urandom_range(8, 1));
        endcase
    endtask

    initial
    begin
        req_t r;
        int   phase_end;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        idle_pct   = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extremes of memory, the ignored low address bits and stray addresses.
        write_word(16'd0, 32'hFFFF_FFFF);
        write_word(16'hFFFF, 32'h0);
        write_word(16'd1, 32'hA5A5_5A5A);
        send_item(make_write(32'h7FFF_FFFC, $urandom));
        send_item(make_write(32'h8004_0000, $urandom));
        r = noise_item();
        r.req_type = REQ_NONE;
        r.byte_address = MEM_BASE;
        r.last_word = 1'b1;
        send_item(r);
        send_item(make_read(MEM_BASE + 32'd2));
        send_item(make_read(32'h8003_FFFF));
        send_item(make_read(32'h8000_0004));
        send_item(make_read(32'hFFFF_FFFF));
        send_item(make_read(32'h0));

        // One word installed and then removed again.
        send_item(make_patch(32'h8000_0004, 32'hA5A5_5A5A, 32'h1234_5678, '1, 32'h0000_FFFF,
                             1'b1, 1'b1, PS_INSTALLABLE));
        send_item(make_patch(32'h8000_0004, 32'hA5A5_5A5A, 32'h1234_5678, '1, 32'h0000_FFFF,
                             1'b1, 1'b0, PS_INSTALLED));
        // An empty search mask matches anything; full write masks replace both words.
        send_item(make_patch(MEM_BASE, $urandom, 32'h0, 32'h0, '1,
                             1'b0, 1'b1, PS_INSTALLABLE | PS_INSTALLED));
        send_item(make_patch(32'h8003_FFFC, $urandom, 32'hFFFF_FFFF, 32'h0, '1,
                             1'b1, 1'b1, PS_INSTALLABLE | PS_INSTALLED));
        // Original word mismatch, write mask outside search mask, wrong states.
        send_item(make_patch(MEM_BASE, 32'h1, $urandom, 32'h1, 32'h0,
                             1'b1, 1'b1, PS_INSTALLABLE));
        send_item(make_patch(32'h8000_0004, $urandom, $urandom, 32'h0, 32'h1,
                             1'b1, 1'b0, PS_INSTALLED));
        send_item(make_patch(MEM_BASE, $urandom, $urandom, 32'h0, '1, 1'b1, 1'b1, PS_NONE));
        send_item(make_patch(MEM_BASE, $urandom, $urandom, 32'h0, '1, 1'b1, 1'b1, PS_INSTALLED));
        // A stray address spoils the whole run even though the last word is fine.
        send_item(make_patch(32'h7FFF_FFFC, $urandom, $urandom, 32'h0, '1,
                             1'b0, 1'b1, PS_INSTALLABLE));
        send_item(make_patch(MEM_BASE, $urandom, $urandom, 32'h0, '1,
                             1'b1, 1'b1, PS_INSTALLABLE));
        send_item(make_read(MEM_BASE));
        send_item(make_read(32'h8003_FFFC));

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 50 : ((phase == 3) ? 21 : 0);
            // A full buffer in one phase, and two words beyond it in another.
            if (phase == 1)
                patch_run(RUN_INSTALL, PATCH_WORDS);
            if (phase == 3)
                patch_run(RUN_INSTALL, PATCH_WORDS + 2);
            // Phase boundaries count from the start, so the long runs share the total.
            phase_end = (phase + 1) * ITEM_TARGET / 4;
            while (items_sent < phase_end)
                random_item();
        end

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("masked_firmware_patch_engine test passed");
        else
            $display("masked_firmware_patch_engine test failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("masked_firmware_patch_engine test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/mfpe_pkg.sv
rtl/mfpe_ram.sv
rtl/masked_firmware_patch_engine.sv
test/mfpe_checker.sv
test/masked_firmware_patch_engine_tb.sv
